### rtl/nfi_pkg.sv
// Package with the shared types, codes and sizes of the flit injector.
`default_nettype none

package nfi_pkg;

   // Message queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Pool reserve product width: node count times packets times flits.
   localparam int NODE_W = 13;
   localparam int PF_W   = 16;
   localparam int NEED_W = NODE_W + PF_W;

   // Input command codes.
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // Result status codes.
   localparam logic STATUS_SENT     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // Flit type codes.
   localparam logic [1:0] FLIT_HEADER = 2'd0;
   localparam logic [1:0] FLIT_INFO   = 2'd1;
   localparam logic [1:0] FLIT_TAIL   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_MISROUTE   = 1'b1;

   localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 13'd16;

   // One queued message as stored in the queue memory.
   typedef struct packed {
      logic [15:0]       tag;
      logic [31:0]       gen_time;
      logic [7:0]        flits;
      logic [7:0]        packets;
      logic signed [7:0] y_offset;
      logic signed [7:0] x_offset;
   } queue_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_CHECK,
      ST_EMIT,
      ST_REJECT
   } state_type;

endpackage

`default_nettype wire

### rtl/nfi_queue_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module nfi_queue_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 80
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/noc_flit_injector_unit.sv
// Top level of the network-on-chip flit injector: message queue and packetizer.
// An accepted enqueue completes at its edge; a rejection is registered after the reject state
// and a flit after the memory read, two multiply stages and the emit state, unless an earlier
// result waits on rsp_ready. A pool-short header tick and an empty or stopped tick send no flit.
// One accepted enqueue per cycle while idle; requests wait while a rejection or tick runs. Reset
// clears pointers, count, stamp and output valid and presets config and indexes, not the memory.
`default_nettype none

module noc_flit_injector_unit
   import nfi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   // Configuration write port.
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic [NODE_W-1:0]  csr_wdata,

   // Request channel.
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [15:0]        req_message_tag,
   input  wire logic signed [7:0]  req_x_offset,
   input  wire logic signed [7:0]  req_y_offset,
   input  wire logic [7:0]         req_packet_count,
   input  wire logic [7:0]         req_flits_per_packet,
   input  wire logic [31:0]        req_generation_time,
   input  wire logic [31:0]        req_current_time,
   input  wire logic               req_output_stopped,
   input  wire logic [23:0]        req_pool_free,

   // Response channel.
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic [1:0]              rsp_flit_type,
   output logic [15:0]             rsp_flit_tag,
   output logic signed [7:0]       rsp_flit_x_offset,
   output logic signed [7:0]       rsp_flit_y_offset,
   output logic signed [7:0]       rsp_flit_misroute,
   output logic [7:0]              rsp_flit_index,
   output logic [7:0]              rsp_packet_index,
   output logic [31:0]             rsp_injection_time,
   output logic                    rsp_message_done
);

   // ------------------------------------------------------------------
   // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
   // ------------------------------------------------------------------
   logic [NODE_W-1:0] node_count_ff;
   logic signed [7:0] misroute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         misroute_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata;
            CSR_MISROUTE:   misroute_ff   <= csr_wdata[7:0];
            default:        node_count_ff <= node_count_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Control state and its next values.
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       flit_num_ff, flit_num_in;
   logic [7:0]       packet_num_ff, packet_num_in;
   logic [31:0]      stamp_ff, stamp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-tick working registers (payload, no reset needed).
   logic [31:0]       now_ff, now_in;
   logic [23:0]       pool_ff, pool_in;
   logic [PF_W-1:0]   pf_ff, pf_in;
   logic [NEED_W-1:0] need_ff, need_in;

   // Output payload registers.
   logic              out_status_ff, out_status_in;
   logic [1:0]        out_type_ff, out_type_in;
   logic [15:0]       out_tag_ff, out_tag_in;
   logic signed [7:0] out_x_ff, out_x_in;
   logic signed [7:0] out_y_ff, out_y_in;
   logic signed [7:0] out_mr_ff, out_mr_in;
   logic [7:0]        out_fidx_ff, out_fidx_in;
   logic [7:0]        out_pidx_ff, out_pidx_in;
   logic [31:0]       out_time_ff, out_time_in;
   logic              out_done_ff, out_done_in;

   // ------------------------------------------------------------------
   // Queue memory. Entries are written at the tail on enqueue and read at
   // the head in the read state, before the multiply, check and emit states
   // form the flit. A read is issued only after the enqueue edge that made
   // the queue non-empty, so read and write never overlap on the same entry.
   // ------------------------------------------------------------------
   queue_entry_type wr_entry;
   queue_entry_type head_entry;
   logic            wr_en;
   logic            rd_en;

   assign wr_entry.tag      = req_message_tag;
   assign wr_entry.gen_time = req_generation_time;
   assign wr_entry.flits    = req_flits_per_packet;
   assign wr_entry.packets  = req_packet_count;
   assign wr_entry.y_offset = req_y_offset;
   assign wr_entry.x_offset = req_x_offset;

   nfi_queue_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(queue_entry_type))
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (head_entry)
   );

   // Message geometry of the head entry; a zero count is treated as one.
   logic [7:0] packets_w;
   logic [7:0] flits_w;
   assign packets_w = (head_entry.packets == 8'd0) ? 8'd1 : head_entry.packets;
   assign flits_w   = (head_entry.flits == 8'd0) ? 8'd1 : head_entry.flits;

   // Header offsets: with misrouting enabled, each magnitude shrinks by one,
   // and a zero offset counts as positive, so it becomes minus one.
   logic signed [7:0] hdr_x;
   logic signed [7:0] hdr_y;
   always_comb begin
      hdr_x = head_entry.x_offset;
      hdr_y = head_entry.y_offset;
      if (misroute_ff != 8'sd0) begin
         hdr_x = head_entry.x_offset[7] ? head_entry.x_offset + 8'sd1
                                        : head_entry.x_offset - 8'sd1;
         hdr_y = head_entry.y_offset[7] ? head_entry.y_offset + 8'sd1
                                        : head_entry.y_offset - 8'sd1;
      end
   end

   logic is_header;
   logic slot_free;
   assign is_header = (flit_num_ff == 8'd1);
   // The output register may be reloaded when empty or drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   // ------------------------------------------------------------------
   // Next state and datapath control.
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      flit_num_in   = flit_num_ff;
      packet_num_in = packet_num_ff;
      stamp_in      = stamp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      now_in        = now_ff;
      pool_in       = pool_ff;
      pf_in         = pf_ff;
      need_in       = need_ff;
      out_status_in = out_status_ff;
      out_type_in   = out_type_ff;
      out_tag_in    = out_tag_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_mr_in     = out_mr_ff;
      out_fidx_in   = out_fidx_ff;
      out_pidx_in   = out_pidx_ff;
      out_time_in   = out_time_ff;
      out_done_in   = out_done_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               now_in  = req_current_time;
               pool_in = req_pool_free;
               if (req_command == CMD_ENQUEUE) begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     state_in = ST_REJECT;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = advance(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff != '0 && !req_output_stopped) begin
                  // A tick with an empty queue or a stopped output does nothing.
                  state_in = ST_READ;
               end
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end

         ST_MUL: begin
            pf_in    = PF_W'(packets_w) * PF_W'(flits_w);
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            need_in  = NEED_W'(node_count_ff) * NEED_W'(pf_ff);
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (is_header && (NEED_W'(pool_ff) < need_ff)) begin
               // Pool too short for the message's reserve: drop the tick, keep all state.
               state_in = ST_IDLE;
            end else if (slot_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               out_status_in = STATUS_SENT;
               out_tag_in    = head_entry.tag;
               out_fidx_in   = flit_num_ff;
               out_pidx_in   = packet_num_ff;
               out_x_in      = '0;
               out_y_in      = '0;
               out_mr_in     = '0;
               out_time_in   = stamp_ff;
               out_done_in   = 1'b0;
               if (is_header) begin
                  out_type_in = FLIT_HEADER;
                  stamp_in    = (now_ff > head_entry.gen_time) ? now_ff
                                                              : head_entry.gen_time;
                  out_time_in = stamp_in;
                  out_x_in    = hdr_x;
                  out_y_in    = hdr_y;
                  out_mr_in   = misroute_ff;
               end else if (flit_num_ff >= flits_w) begin
                  out_type_in = FLIT_TAIL;
               end else begin
                  out_type_in = FLIT_INFO;
               end

               if (flit_num_ff < flits_w) begin
                  flit_num_in = flit_num_ff + 8'd1;
               end else if (packet_num_ff < packets_w) begin
                  packet_num_in = packet_num_ff + 8'd1;
                  flit_num_in   = 8'd1;
               end else begin
                  // Final flit of the message: retire the head entry.
                  out_done_in   = 1'b1;
                  flit_num_in   = 8'd1;
                  packet_num_in = 8'd1;
                  head_in       = advance(head_ff);
                  count_in      = count_ff - 1'b1;
               end
            end
         end

         ST_REJECT: begin
            if (slot_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               out_status_in = STATUS_REJECTED;
               out_type_in   = FLIT_HEADER;
               out_tag_in    = '0;
               out_x_in      = '0;
               out_y_in      = '0;
               out_mr_in     = '0;
               out_fidx_in   = '0;
               out_pidx_in   = '0;
               out_time_in   = '0;
               out_done_in   = 1'b0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         flit_num_ff   <= 8'd1;
         packet_num_ff <= 8'd1;
         stamp_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         flit_num_ff   <= flit_num_in;
         packet_num_ff <= packet_num_in;
         stamp_ff      <= stamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      pool_ff       <= pool_in;
      pf_ff         <= pf_in;
      need_ff       <= need_in;
      out_status_ff <= out_status_in;
      out_type_ff   <= out_type_in;
      out_tag_ff    <= out_tag_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_mr_ff     <= out_mr_in;
      out_fidx_ff   <= out_fidx_in;
      out_pidx_ff   <= out_pidx_in;
      out_time_ff   <= out_time_in;
      out_done_ff   <= out_done_in;
   end

   // ------------------------------------------------------------------
   // Response outputs come straight from the output register.
   // ------------------------------------------------------------------
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_flit_type      = out_type_ff;
   assign rsp_flit_tag       = out_tag_ff;
   assign rsp_flit_x_offset  = out_x_ff;
   assign rsp_flit_y_offset  = out_y_ff;
   assign rsp_flit_misroute  = out_mr_ff;
   assign rsp_flit_index     = out_fidx_ff;
   assign rsp_packet_index   = out_pidx_ff;
   assign rsp_injection_time = out_time_ff;
   assign rsp_message_done   = out_done_ff;

endmodule

`default_nettype wire
